### hdl/rgba_area_box_downscale_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA area-box downscaler
// Implication checks sampled on the rising clock, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef RGBA_AREA_BOX_DOWNSCALE_TOP_MACROS_SVH
`define RGBA_AREA_BOX_DOWNSCALE_TOP_MACROS_SVH

// Same-cycle implication
`define RABD_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rabd check failed");

// Next-cycle implication
`define RABD_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rabd next-cycle check failed");

`endif

### hdl/rabd_pkg.sv
// ----------------------------------------------------------------------------
// rabd_pkg
// Types and fixed constants shared by the downscaler front, back and top.
// ----------------------------------------------------------------------------
package rabd_pkg;

    localparam int CH_W      = 8;   // one color channel
    localparam int NUM_CH    = 4;   // red, green, blue, alpha
    localparam int SUM_W     = 10;  // line store entry per channel
    localparam int RACC_W    = 10;  // row accumulator per channel
    localparam int ACC_W     = 11;  // row accumulator plus new pixel
    localparam int TOTAL_W   = 12;  // line store entry plus accumulator

    localparam int SW_W      = 10;
    localparam int SH_W      = 13;
    localparam int DW_W      = 9;
    localparam int DH_W      = 13;
    localparam int SCOL_W    = 10;
    localparam int SROW_W    = 12;
    localparam int DROW_W    = 12;
    localparam int CREM_W    = 10;
    localparam int RREM_W    = 13;
    localparam int MAX_H     = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam logic [SW_W-1:0] RST_SRC_WIDTH  = 10'd160;
    localparam logic [SH_W-1:0] RST_SRC_HEIGHT = 13'd160;
    localparam logic [DW_W-1:0] RST_DST_WIDTH  = 9'd80;
    localparam logic [DH_W-1:0] RST_DST_HEIGHT = 13'd80;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic [NUM_CH-1:0][CH_W-1:0]  t_pix;
    typedef logic [NUM_CH-1:0][ACC_W-1:0] t_acc;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sums;

    // One column-box end (or one flagged pixel) handed from front to back
    typedef struct packed {
        logic bad;          // illegal sizes: emit flagged result only
        logic clear;        // empty the line store before this command
        logic row_box_end;  // box finished: emit result, release entry
        logic shift_col;    // box is two columns wide
        logic shift_row;    // box is two rows tall
        logic row_end;
        logic frame_end;
        t_acc acc;
    } t_cmd;

    typedef struct packed {
        t_pix pix;
        logic row_end;
        logic frame_end;
        logic bad;
    } t_res;

endpackage

### hdl/rabd_fifo.sv
// ----------------------------------------------------------------------------
// rabd_fifo
// Small register-based queue with occupancy count.
// ----------------------------------------------------------------------------
module rabd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/rabd_ram.sv
// ----------------------------------------------------------------------------
// rabd_ram
// Generic simple dual-port RAM, registered read, read returns old data.
// ----------------------------------------------------------------------------
module rabd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hdl/rabd_front.sv
// ----------------------------------------------------------------------------
// rabd_front
// Holds the size registers, tracks the raster position, accumulates the left
// pixel of two-wide boxes and issues one command per column-box end or bad pixel.
// ----------------------------------------------------------------------------
module rabd_front #(
    parameter int MAX_DEST_WIDTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [rabd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rabd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  rabd_pkg::t_pix                      i_pix,
    input  logic                                i_frame_first,
    output logic                                o_cmd_push,
    output rabd_pkg::t_cmd                      o_cmd,
    output logic [((MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1)-1:0] o_cmd_slot
);

    import rabd_pkg::*;

    localparam int DC_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
    localparam logic [DH_W-1:0] MAX_DW = DH_W'(MAX_DEST_WIDTH);
    localparam logic [SH_W-1:0] MAX_HT = SH_W'(MAX_H);

    logic [SW_W-1:0]   r_sw;
    logic [SH_W-1:0]   r_sh;
    logic [DW_W-1:0]   r_dw;
    logic [DH_W-1:0]   r_dh;
    logic              r_restart_pend, r_clear_pend;
    logic [SCOL_W-1:0] r_sc, n_sc, e_sc;
    logic [SROW_W-1:0] r_sr, n_sr, e_sr;
    logic [DC_W-1:0]   r_dc, n_dc, e_dc;
    logic [DROW_W-1:0] r_dr, n_dr, e_dr;
    logic [CREM_W-1:0] r_crem, n_crem, e_crem;
    logic [RREM_W-1:0] r_rrem, n_rrem, e_rrem;
    logic [NUM_CH-1:0][RACC_W-1:0] r_racc, n_racc, e_racc;

    logic              good, restart, clear_eff;
    logic              last_col, last_row, col_end, rbe, rend;
    logic [SW_W-1:0]   sw_dw;
    logic [SH_W-1:0]   sh_dh;
    t_acc              acc;
    logic [SW_W:0]     crem_up;
    logic [RREM_W:0]   rrem_up;

    // Legal sizes: dst <= src <= 2*dst on each axis, nothing zero or too big
    always_comb begin
        good = (r_sw != '0) && (r_sh != '0) && (r_dw != '0) && (r_dh != '0)
            && ({4'b0, r_dw} <= MAX_DW) && (r_sh <= MAX_HT) && (r_dh <= MAX_HT)
            && ({1'b0, r_dw} <= r_sw) && ({1'b0, r_sw} <= {1'b0, r_dw, 1'b0})
            && (r_dh <= r_sh) && ({1'b0, r_sh} <= {r_dh, 1'b0});
    end

    assign sw_dw = r_sw - {1'b0, r_dw};
    assign sh_dh = r_sh - r_dh;

    always_comb begin
        restart   = i_frame_first || r_restart_pend;
        clear_eff = r_clear_pend || restart;
        e_sc   = restart ? '0 : r_sc;
        e_sr   = restart ? '0 : r_sr;
        e_dc   = restart ? '0 : r_dc;
        e_dr   = restart ? '0 : r_dr;
        e_crem = restart ? sw_dw : r_crem;
        e_rrem = restart ? sh_dh : r_rrem;
        e_racc = restart ? '0 : r_racc;

        for (int c = 0; c < NUM_CH; c++) begin
            acc[c] = ACC_W'(e_racc[c]) + ACC_W'(i_pix[c]);
        end

        last_col = ((SW_W + 1)'(e_sc) + 1'b1) >= {1'b0, r_sw};
        last_row = (SH_W'(e_sr) + 1'b1) >= r_sh;
        col_end  = (e_crem < {1'b0, r_dw}) || last_col;
        rbe      = (e_rrem < r_dh) || last_row;
        rend     = (DH_W'(e_dc) + 1'b1) >= DH_W'(r_dw);

        // Advance the position and the step remainders
        n_sc   = e_sc;
        n_sr   = e_sr;
        n_dc   = e_dc;
        n_dr   = e_dr;
        n_crem = e_crem;
        n_rrem = e_rrem;
        crem_up = '0;
        rrem_up = '0;
        if (last_col) begin
            n_sc   = '0;
            n_dc   = '0;
            n_crem = sw_dw;
            if (last_row) begin
                n_sr   = '0;
                n_dr   = '0;
                n_rrem = sh_dh;
            end else begin
                rrem_up = rbe ? ({1'b0, e_rrem} + {1'b0, r_sh}) : {1'b0, e_rrem};
                n_rrem  = RREM_W'(rrem_up - {1'b0, r_dh});
                n_dr    = rbe ? e_dr + 1'b1 : e_dr;
                n_sr    = e_sr + 1'b1;
            end
        end else begin
            crem_up = col_end ? ({1'b0, e_crem} + {1'b0, r_sw}) : {1'b0, e_crem};
            n_crem  = CREM_W'(crem_up - {2'b0, r_dw});
            n_dc    = col_end ? e_dc + 1'b1 : e_dc;
            n_sc    = e_sc + 1'b1;
        end

        for (int c = 0; c < NUM_CH; c++) begin
            n_racc[c] = col_end ? '0 : acc[c][RACC_W-1:0];
        end

        // Command: flagged pixel, or end of a column box
        o_cmd_push = i_accept && (!good || col_end);
        o_cmd_slot = good ? e_dc : '0;
        o_cmd      = '0;
        if (!good) begin
            o_cmd.bad = 1'b1;
        end else begin
            o_cmd.clear       = clear_eff;
            o_cmd.row_box_end = rbe;
            o_cmd.shift_col   = e_crem < sw_dw;
            o_cmd.shift_row   = e_rrem < sh_dh;
            o_cmd.row_end     = rend;
            o_cmd.frame_end   = rend && ((SH_W'(e_dr) + 1'b1) >= r_dh);
            o_cmd.acc         = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw           <= RST_SRC_WIDTH;
            r_sh           <= RST_SRC_HEIGHT;
            r_dw           <= RST_DST_WIDTH;
            r_dh           <= RST_DST_HEIGHT;
            r_restart_pend <= 1'b1;
            r_clear_pend   <= 1'b1;
            r_sc           <= '0;
            r_sr           <= '0;
            r_dc           <= '0;
            r_dr           <= '0;
            r_crem         <= '0;
            r_rrem         <= '0;
            r_racc         <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_sw <= i_cfg_data[SW_W-1:0];
                CFG_SRC_HEIGHT: r_sh <= i_cfg_data[SH_W-1:0];
                CFG_DST_WIDTH:  r_dw <= i_cfg_data[DW_W-1:0];
                CFG_DST_HEIGHT: r_dh <= i_cfg_data[DH_W-1:0];
                default: ;
            endcase
            // Restart position and empty the line store on the next pixel
            r_restart_pend <= 1'b1;
            r_clear_pend   <= 1'b1;
        end else if (i_accept && good) begin
            r_restart_pend <= 1'b0;
            r_clear_pend   <= col_end ? 1'b0 : clear_eff;
            r_sc           <= n_sc;
            r_sr           <= n_sr;
            r_dc           <= n_dc;
            r_dr           <= n_dr;
            r_crem         <= n_crem;
            r_rrem         <= n_rrem;
            r_racc         <= n_racc;
        end
    end

endmodule

### hdl/rabd_back.sv
// ----------------------------------------------------------------------------
// rabd_back
// Executes commands against the column-sum line store: read the entry, then
// add, then write the sum back or emit it divided by shift.
// ----------------------------------------------------------------------------
`include "rgba_area_box_downscale_top_macros.svh"

module rabd_back #(
    parameter int MAX_DEST_WIDTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_empty,
    input  rabd_pkg::t_cmd                      i_cmd,
    input  logic [((MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1)-1:0] i_cmd_slot,
    output logic                                o_cmd_pop,
    input  logic [rabd_pkg::OUT_CNT_W-1:0]      i_out_count,
    output logic                                o_res_push,
    output rabd_pkg::t_res                      o_res
);

    import rabd_pkg::*;

    localparam int SLOT_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;

    logic                  r_s1_valid;
    t_cmd                  r_s1;
    logic [SLOT_W-1:0]     r_s1_slot;
    logic [MAX_DEST_WIDTH-1:0] r_valid, n_valid;
    logic                  r_fwd_en;
    logic [SLOT_W-1:0]     r_fwd_slot;
    t_sums                 r_fwd_data;

    t_sums                 ram_q, wr_data;
    logic [SUM_W*NUM_CH-1:0] ram_q_raw;
    logic                  wr_en, fwd_hit, use_old;
    logic [1:0]            shift;
    logic [NUM_CH-1:0][TOTAL_W-1:0] total;
    logic [SUM_W-1:0]      base;

    // Hold back a command unless the result queue has room for it
    assign o_cmd_pop = !i_cmd_empty
        && (({1'b0, i_out_count} + {{OUT_CNT_W{1'b0}}, r_s1_valid})
            < (OUT_CNT_W + 1)'(OUT_DEPTH));

    rabd_ram #(
        .WIDTH (SUM_W * NUM_CH),
        .DEPTH (MAX_DEST_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (o_cmd_pop),
        .i_rd_addr (i_cmd_slot),
        .o_rd_data (ram_q_raw)
    );

    assign ram_q = ram_q_raw;

    always_comb begin
        // The read issued last cycle misses a write made in that same cycle
        fwd_hit = r_fwd_en && (r_fwd_slot == r_s1_slot);
        use_old = !r_s1.clear && r_valid[r_s1_slot];
        shift   = {1'b0, r_s1.shift_col} + {1'b0, r_s1.shift_row};
        base    = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            base       = !use_old ? '0 : (fwd_hit ? r_fwd_data[c] : ram_q[c]);
            total[c]   = TOTAL_W'(base) + TOTAL_W'(r_s1.acc[c]);
            wr_data[c] = total[c][SUM_W-1:0];
        end

        wr_en      = r_s1_valid && !r_s1.bad && !r_s1.row_box_end;
        o_res_push = r_s1_valid && (r_s1.bad || r_s1.row_box_end);
        o_res      = '0;
        if (r_s1.bad) begin
            o_res.bad = 1'b1;
        end else begin
            for (int c = 0; c < NUM_CH; c++) begin
                o_res.pix[c] = CH_W'(total[c] >> shift);
            end
            o_res.row_end   = r_s1.row_end;
            o_res.frame_end = r_s1.frame_end;
        end

        // Finished boxes release their entry; partial boxes mark it live
        n_valid = r_valid;
        if (r_s1_valid && !r_s1.bad) begin
            if (r_s1.clear) begin
                n_valid = '0;
            end
            n_valid[r_s1_slot] = !r_s1.row_box_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
            r_valid    <= '0;
        end else begin
            r_s1_valid <= o_cmd_pop;
            r_fwd_en   <= wr_en;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1      <= i_cmd;
            r_s1_slot <= i_cmd_slot;
        end
        if (wr_en) begin
            r_fwd_slot <= r_s1_slot;
            r_fwd_data <= wr_data;
        end
    end

    `RABD_CHECK_NEXT(a_exec_after_pop, i_clk, i_rst_n, o_cmd_pop, r_s1_valid)
    `RABD_CHECK(a_res_has_room, i_clk, i_rst_n, o_res_push, i_out_count < OUT_CNT_W'(OUT_DEPTH))
    `RABD_CHECK_NEXT(a_clear_empties, i_clk, i_rst_n, r_s1_valid && r_s1.clear && !r_s1.bad, $countones(r_valid) <= 1)

endmodule

### hdl/rgba_area_box_downscale_top.sv
// ----------------------------------------------------------------------------
// rgba_area_box_downscale_top
// Streaming area-average downscaler for RGBA pixels in raster order.
// ----------------------------------------------------------------------------
//   Input: a pixel transfers at a rising edge with push high and full low;
//   frame_first marks the first pixel of a frame.
//   Output: the oldest result sits on the o_out_* ports while empty is low
//   and transfers at a rising edge with pop high and empty low.
//   Config: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
//   i_cfg_data; write only while the block is idle.
//   Throughput: one pixel per cycle while full is low, set by the line store
//   read-modify-write (one read, one write port, previous write forwarded).
//   Path: command queue, the back's execute register, then the result queue;
//   with legal sizes, pixels that close no box produce nothing.
//   Reset: sizes return to 160x160 -> 80x80, position counters restart at
//   the first pixel, both queues empty and per-entry valid flags make every
//   line store entry read as empty; no clearing pass is run.
//   Receiver stall: the four-entry result queue fills, commands collect in
//   the four-entry command queue, then full rises until pop resumes.
// ----------------------------------------------------------------------------
`include "rgba_area_box_downscale_top_macros.svh"

module rgba_area_box_downscale_top #(
    parameter int MAX_DEST_WIDTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // source pixel queue
    input  logic                            push,
    output logic                            full,
    input  logic [rabd_pkg::CH_W-1:0]       i_in_red,
    input  logic [rabd_pkg::CH_W-1:0]       i_in_green,
    input  logic [rabd_pkg::CH_W-1:0]       i_in_blue,
    input  logic [rabd_pkg::CH_W-1:0]       i_in_alpha,
    input  logic                            i_frame_first,
    // result queue
    output logic                            empty,
    input  logic                            pop,
    output logic [rabd_pkg::CH_W-1:0]       o_out_red,
    output logic [rabd_pkg::CH_W-1:0]       o_out_green,
    output logic [rabd_pkg::CH_W-1:0]       o_out_blue,
    output logic [rabd_pkg::CH_W-1:0]       o_out_alpha,
    output logic                            o_row_end,
    output logic                            o_frame_end,
    output logic                            o_settings_bad,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rabd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rabd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import rabd_pkg::*;

    localparam int SLOT_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
    localparam int CMD_W  = $bits(t_cmd) + SLOT_W;

    logic              accept, cfg_write;
    t_pix              pix;
    logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd              cmd_in, cmd_out;
    logic [SLOT_W-1:0] slot_in, slot_out;
    logic              res_push, res_full;
    t_res              res_in, res_out;
    logic [OUT_CNT_W-1:0] out_count;

    // Configuration is always taken at once
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign pix    = {i_in_alpha, i_in_blue, i_in_green, i_in_red};

    // Front: position tracking and classification
    rabd_front #(
        .MAX_DEST_WIDTH (MAX_DEST_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_write),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pix         (pix),
        .i_frame_first (i_frame_first),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .o_cmd_slot    (slot_in)
    );

    // Decouple front and back so each side stalls on its own
    rabd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({cmd_in, slot_in}),
        .i_pop   (cmd_pop),
        .o_data  ({cmd_out, slot_out}),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    // Back: line store update and result generation
    rabd_back #(
        .MAX_DEST_WIDTH (MAX_DEST_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .i_cmd_slot  (slot_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue; the back reserves room before it issues, so no drop
    rabd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_out_red      = res_out.pix[0];
    assign o_out_green    = res_out.pix[1];
    assign o_out_blue     = res_out.pix[2];
    assign o_out_alpha    = res_out.pix[3];
    assign o_row_end      = res_out.row_end;
    assign o_frame_end    = res_out.frame_end;
    assign o_settings_bad = res_out.bad;

    `RABD_CHECK(a_no_push_when_full, i_clk, i_rst_n, res_push, !res_full)
    `RABD_CHECK_NEXT(a_idle_back_stays_quiet, i_clk, i_rst_n, cmd_empty && !cmd_push, !cmd_pop)
    `RABD_CHECK(a_full_blocks_cmd, i_clk, i_rst_n, cmd_full, !accept)

endmodule
